// ===== hw/rtl/hkar_pkg.sv =====
// Package for the hotkey press and autorepeat block.
// Holds the transaction payload types, command and register codes, and reset constants.
// No dependencies.
`default_nettype none

package hkar_pkg;

  // Item kinds carried in the mode field.
  localparam logic MODE_BIND = 1'b0;
  localparam logic MODE_POLL = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_DEFAULT_DELAY = 1'b0;
  localparam logic CFG_CAPTURE       = 1'b1;

  // Register reset values.
  localparam logic [15:0] DEFAULT_DELAY_RESET = 16'd100;

  // Field widths fixed by the interface.
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned NOW_W   = 48;
  localparam int unsigned DELAY_W = 16;

  typedef struct packed {
    logic               mode;
    logic [SLOT_W-1:0]  slot;
    logic               key_down;
    logic [NOW_W-1:0]   now_ms;
    logic               window_focused;
    logic               repeat_enable;
    logic [DELAY_W-1:0] repeat_delay;
    logic               wheel_binding;
  } in_item_t;

  typedef struct packed {
    logic              fire;
    logic [SLOT_W-1:0] fired_slot;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hkar_ram.sv =====
// Simple dual-port synchronous RAM for the slot table.
// One write port and one read port with a registered read; no dependencies.
`default_nettype none

module hkar_ram #(
  parameter int unsigned WIDTH = 67,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hkar_update.sv =====
// Slot update logic: computes the fire decision and the new table entry for one item.
// Depends on hkar_pkg for the item type and mode codes.
`default_nettype none

module hkar_update #(
  parameter int unsigned TIME_BITS = 48
) (
  input  wire hkar_pkg::in_item_t   item,
  input  wire logic                 in_range,
  input  wire logic [15:0]          default_delay,
  input  wire logic                 capture,
  // Current entry.
  input  wire logic                 cur_held,
  input  wire logic                 cur_rep_en,
  input  wire logic                 cur_wheel,
  input  wire logic [15:0]          cur_delay,
  input  wire logic [TIME_BITS-1:0] cur_due,
  // Decision and new entry.
  output logic                      fire,
  output logic                      wr_en,
  output logic                      new_held,
  output logic                      new_rep_en,
  output logic                      new_wheel,
  output logic [15:0]               new_delay,
  output logic [TIME_BITS-1:0]      new_due
);

  import hkar_pkg::*;

  logic [63:0]          now_wide;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS:0]   due_sum;
  logic [TIME_BITS-1:0] due_sat;
  logic                 active;

  // Time masked to the stored width.
  assign now_wide = {16'b0, item.now_ms};
  assign now_t    = now_wide[TIME_BITS-1:0];

  // Next due time, saturating at the largest time value.
  assign due_sum = {1'b0, now_t} + (TIME_BITS+1)'(cur_delay);
  assign due_sat = due_sum[TIME_BITS] ? '1 : due_sum[TIME_BITS-1:0];

  assign active = in_range && (item.mode == MODE_POLL)
                  && (item.window_focused || capture);

  // Bind programs the slot; a poll walks the wheel, press, hold and release cases.
  always_comb begin
    fire       = 1'b0;
    wr_en      = 1'b0;
    new_held   = cur_held;
    new_rep_en = cur_rep_en;
    new_wheel  = cur_wheel;
    new_delay  = cur_delay;
    new_due    = cur_due;
    if (in_range && (item.mode == MODE_BIND)) begin
      wr_en      = 1'b1;
      new_rep_en = item.repeat_enable;
      new_wheel  = item.wheel_binding;
      new_delay  = (item.repeat_delay != '0) ? item.repeat_delay : default_delay;
      new_held   = 1'b0;
      new_due    = '0;
    end else if (active) begin
      wr_en = 1'b1;
      if (cur_wheel) begin
        fire     = item.key_down;
        new_held = 1'b0;
        new_due  = '0;
      end else if (!item.key_down) begin
        new_held = 1'b0;
        new_due  = '0;
      end else if (!cur_held) begin
        fire     = 1'b1;
        new_held = 1'b1;
        if (cur_rep_en) begin
          new_due = due_sat;
        end
      end else if (cur_rep_en && (now_t >= cur_due)) begin
        fire    = 1'b1;
        new_due = due_sat;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hotkey_press_autorepeat.sv =====
// Top level of the hotkey press detector with typematic autorepeat.
// Depends on hkar_pkg, hkar_ram and hkar_update.
//
//   channel | ports                               | moves
//   --------+-------------------------------------+-------------------------------
//   input   | in_valid, in_ready, in_data         | bind or poll item for one slot
//   result  | out_valid, out_ready, out_data      | fire flag and echoed slot
//   config  | cfg_valid, cfg_ready, cfg_index/data | register write, always ready
//
// Accepting an item issues the slot table read; the registered read data then feeds
// the update, which writes the entry back and loads the output register.
// in_ready is low while an item is in flight, so a read never overlaps a write.
// A full output register holds the in-flight item until out_ready frees it.
// Reset clears the per-slot valid bits at once; an unwritten slot reads as zero.
`default_nettype none

module hotkey_press_autorepeat #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned TIME_BITS  = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire hkar_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output hkar_pkg::out_item_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_index,
  input  wire logic [15:0]          cfg_data
);

  import hkar_pkg::*;

  localparam int unsigned AW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned ENTRY_W = TIME_BITS + 19;

  // Configuration registers.
  logic [15:0] default_delay_r, default_delay_nxt;
  logic        capture_r, capture_nxt;

  // In-flight item and output register.
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Per-slot valid bits.
  logic [SLOT_COUNT-1:0] slot_valid_r, slot_valid_nxt;

  logic                 in_fire;
  logic                 s1_done;
  logic [7:0]           in_slot_wide;
  logic [7:0]           s1_slot_wide;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        s1_idx;
  logic                 s1_in_range;
  logic [ENTRY_W-1:0]   rd_data;
  logic [ENTRY_W-1:0]   cur_entry;
  logic [ENTRY_W-1:0]   wr_data;
  logic                 upd_fire;
  logic                 upd_wr;
  logic                 new_held;
  logic                 new_rep_en;
  logic                 new_wheel;
  logic [15:0]          new_delay;
  logic [TIME_BITS-1:0] new_due;

  // Handshakes.
  assign in_ready  = !s1_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign s1_done   = s1_valid_r && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Slot addressing.
  assign in_slot_wide = {4'b0, in_data.slot};
  assign s1_slot_wide = {4'b0, s1_item_r.slot};
  assign rd_addr      = in_slot_wide[AW-1:0];
  assign s1_idx       = s1_slot_wide[AW-1:0];
  assign s1_in_range  = 32'(s1_item_r.slot) < SLOT_COUNT;

  // Slot table.
  hkar_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (s1_done && upd_wr),
    .wr_addr (s1_idx),
    .wr_data (wr_data)
  );

  // An entry never written reads as all zero.
  assign cur_entry = (s1_in_range && slot_valid_r[s1_idx]) ? rd_data : '0;

  hkar_update #(
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .item          (s1_item_r),
    .in_range      (s1_in_range),
    .default_delay (default_delay_r),
    .capture       (capture_r),
    .cur_held      (cur_entry[ENTRY_W-1]),
    .cur_rep_en    (cur_entry[ENTRY_W-2]),
    .cur_wheel     (cur_entry[ENTRY_W-3]),
    .cur_delay     (cur_entry[TIME_BITS+15:TIME_BITS]),
    .cur_due       (cur_entry[TIME_BITS-1:0]),
    .fire          (upd_fire),
    .wr_en         (upd_wr),
    .new_held      (new_held),
    .new_rep_en    (new_rep_en),
    .new_wheel     (new_wheel),
    .new_delay     (new_delay),
    .new_due       (new_due)
  );

  assign wr_data = {new_held, new_rep_en, new_wheel, new_delay, new_due};

  // Next-state logic for control, valid bits, output and configuration.
  always_comb begin
    s1_valid_nxt      = s1_valid_r;
    out_valid_nxt     = out_valid_r;
    out_data_nxt      = out_data_r;
    slot_valid_nxt    = slot_valid_r;
    default_delay_nxt = default_delay_r;
    capture_nxt       = capture_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_done) begin
      s1_valid_nxt            = 1'b0;
      out_valid_nxt           = 1'b1;
      out_data_nxt.fire       = upd_fire;
      out_data_nxt.fired_slot = s1_item_r.slot;
      if (upd_wr) begin
        slot_valid_nxt[s1_idx] = 1'b1;
      end
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEFAULT_DELAY: default_delay_nxt = cfg_data;
        CFG_CAPTURE:       capture_nxt       = cfg_data[0];
        default:           default_delay_nxt = default_delay_r;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      slot_valid_r    <= '0;
      default_delay_r <= DEFAULT_DELAY_RESET;
      capture_r       <= 1'b0;
    end else begin
      s1_valid_r      <= s1_valid_nxt;
      out_valid_r     <= out_valid_nxt;
      slot_valid_r    <= slot_valid_nxt;
      default_delay_r <= default_delay_nxt;
      capture_r       <= capture_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      s1_item_r <= in_data;
    end
  end

endmodule

`default_nettype wire
